// ===== sv/cca_pkg.sv =====
// Shared constants, codes and control/status types of the cyclic cellular automaton.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cca_pkg;

  // Grid geometry and cell format.
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int CELL_BITS  = 8;
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int SUCC_W     = CELL_BITS + 1;
  localparam int TBL_DEPTH  = 2 ** CELL_BITS;

  // Configuration register widths.
  localparam int NS_W    = 9;
  localparam int DIM_W   = 7;
  localparam int GEN_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  // Taps of the two-row window line; tap 0 holds the newest cell.
  localparam int LINE_LEN  = 2 * MAX_COLS + 1;
  localparam int TAP_DOWN  = 0;
  localparam int TAP_RIGHT = MAX_COLS - 1;
  localparam int TAP_MID   = MAX_COLS;
  localparam int TAP_LEFT  = MAX_COLS + 1;
  localparam int TAP_UP    = 2 * MAX_COLS;

  typedef enum logic [1:0] {
    REQ_WRITE,
    REQ_RUN,
    REQ_READ
  } req_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_STATES,
    CFG_GRID_ROWS,
    CFG_GRID_COLS,
    CFG_GEN_COUNT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_TABLE,
    ST_START,
    ST_GEN,
    ST_REPLY
  } cca_state_t;

  typedef struct packed {
    logic capture;      // latch the accepted request
    logic cell_write;   // store the request value in the front buffer
    logic res_set;      // latch the pending result
    logic run_load;     // load generation counter and restart the table build
    logic tbl_step;     // write one successor table entry
    logic sweep_start;  // begin one generation sweep
    logic gen_end;      // swap buffers and count one generation
    logic out_load;     // move the pending result to the output register
  } cca_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       bad;
    logic       tbl_last;
    logic       gens_zero;
    logic       gens_last;
    logic       sweep_done;
    logic       out_free;
  } cca_stat_t;

endpackage

// ===== sv/cca_ctrl.sv =====
// Request sequencer of the cyclic cellular automaton.
// Depends on cca_pkg; drives cca_datapath through cca_cmd_t and reads cca_stat_t.
`timescale 1ns / 1ps

module cca_ctrl import cca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cca_stat_t stat,
  output cca_cmd_t  cmd
);

  cca_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat.req)
          REQ_READ: state_nxt = stat.bad ? ST_REPLY : ST_READ;
          REQ_RUN:  state_nxt = ST_TABLE;
          default:  state_nxt = ST_REPLY;
        endcase
      end
      ST_READ: state_nxt = ST_REPLY;
      ST_TABLE: begin
        if (stat.tbl_last) state_nxt = stat.gens_zero ? ST_REPLY : ST_START;
      end
      ST_START: state_nxt = ST_GEN;
      ST_GEN: begin
        if (stat.sweep_done) state_nxt = stat.gens_last ? ST_REPLY : ST_START;
      end
      ST_REPLY: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        case (stat.req)
          REQ_WRITE: begin
            cmd.cell_write = !stat.bad;
            cmd.res_set    = 1'b1;
          end
          REQ_READ: cmd.res_set = stat.bad;
          REQ_RUN: begin
            cmd.run_load = 1'b1;
            cmd.res_set  = 1'b1;
          end
          default: cmd.res_set = 1'b1;
        endcase
      end
      ST_READ:  cmd.res_set     = 1'b1;
      ST_TABLE: cmd.tbl_step    = 1'b1;
      ST_START: cmd.sweep_start = 1'b1;
      ST_GEN:   cmd.gen_end     = stat.sweep_done;
      ST_REPLY: cmd.out_load    = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== sv/cca_datapath.sv =====
// Datapath of the cyclic cellular automaton: both grid buffers, the successor
// table, the sweep pipeline with its two-row window, and the result registers.
// Depends on cca_pkg; sequenced by cca_ctrl.
`timescale 1ns / 1ps

module cca_datapath import cca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_req,
  input  logic [ROW_W-1:0]     in_row,
  input  logic [COL_W-1:0]     in_col,
  input  logic [CELL_BITS-1:0] in_wval,
  input  logic [NS_W-1:0]      num_states,
  input  logic [DIM_W-1:0]     grid_rows,
  input  logic [DIM_W-1:0]     grid_cols,
  input  logic [GEN_W-1:0]     generation_count,
  input  cca_cmd_t             cmd,
  output cca_stat_t            stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [CELL_BITS-1:0] out_value,
  output logic                 out_error
);

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  // Captured request.
  logic [1:0]           req_r;
  logic [ROW_W-1:0]     row_r;
  logic [COL_W-1:0]     col_r;
  logic [CELL_BITS-1:0] wval_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req;
      row_r  <= in_row;
      col_r  <= in_col;
      wval_r <= in_wval;
    end
  end

  logic [DIM_W-1:0] rows_used, cols_used;
  logic             in_range, bad;

  assign rows_used = (grid_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows;
  assign cols_used = (grid_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols;
  assign in_range  = (DIM_W'(row_r) < rows_used) && (DIM_W'(col_r) < cols_used);

  always_comb begin
    case (req_r)
      REQ_WRITE: bad = !in_range || (NS_W'(wval_r) >= num_states);
      REQ_READ:  bad = !in_range;
      REQ_RUN:   bad = 1'b0;
      default:   bad = 1'b1;
    endcase
  end

  // Generation counter and buffer roles.
  logic [GEN_W-1:0] gens_left_r;
  logic             front_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gens_left_r <= '0;
      front_sel_r <= 1'b0;
    end else if (cmd.run_load) begin
      gens_left_r <= generation_count;
    end else if (cmd.gen_end) begin
      gens_left_r <= gens_left_r - 1'b1;
      front_sel_r <= !front_sel_r;
    end
  end

  // Successor table: entry u holds (u + 1) mod num_states, or u + 1 if it is
  // zero, built by a running remainder so that no divider is needed.
  logic [CELL_BITS-1:0] tbl_idx_r;
  logic [NS_W-1:0]      tbl_acc_r;
  logic [SUCC_W-1:0]    tbl_entry;
  logic [SUCC_W-1:0]    tbl_mem [TBL_DEPTH];
  logic [SUCC_W-1:0]    tbl_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_idx_r <= '0;
      tbl_acc_r <= '0;
    end else if (cmd.run_load) begin
      tbl_idx_r <= '0;
      tbl_acc_r <= (num_states == NS_W'(1)) ? '0 : NS_W'(1);
    end else if (cmd.tbl_step) begin
      tbl_idx_r <= tbl_idx_r + 1'b1;
      tbl_acc_r <= (tbl_acc_r + 1'b1 == num_states) ? '0 : tbl_acc_r + 1'b1;
    end
  end

  assign tbl_entry = (num_states == '0) ? SUCC_W'(tbl_idx_r) + SUCC_W'(1)
                                        : SUCC_W'(tbl_acc_r);

  always_ff @(posedge clk) begin
    if (cmd.tbl_step) tbl_mem[tbl_idx_r] <= tbl_entry;
  end

  // Sweep issue: every row streams all MAX_COLS columns, then one extra row of
  // dummy beats pushes the last real row through the window.
  logic             iss_act_r;
  logic [DIM_W-1:0] iss_row_r;
  logic [COL_W-1:0] iss_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_act_r <= 1'b0;
      iss_row_r <= '0;
      iss_col_r <= '0;
    end else if (cmd.sweep_start) begin
      iss_act_r <= 1'b1;
      iss_row_r <= '0;
      iss_col_r <= '0;
    end else if (iss_act_r) begin
      if (iss_col_r == COL_W'(MAX_COLS - 1)) begin
        iss_col_r <= '0;
        if (iss_row_r == rows_used) iss_act_r <= 1'b0;
        else iss_row_r <= iss_row_r + 1'b1;
      end else begin
        iss_col_r <= iss_col_r + 1'b1;
      end
    end
  end

  // Grid buffers.
  logic [CELL_BITS-1:0] mem_a [CELL_COUNT];
  logic [CELL_BITS-1:0] mem_b [CELL_COUNT];
  logic [CELL_BITS-1:0] rd_a_r, rd_b_r, src_data;
  logic [ADDR_W-1:0]    rd_addr, wr_addr, req_addr, gen_addr;
  logic [CELL_BITS-1:0] wr_data, new_val;
  logic                 gen_we, we_a, we_b;

  assign req_addr = cell_addr(row_r, col_r);
  assign rd_addr  = iss_act_r ? cell_addr(iss_row_r[ROW_W-1:0], iss_col_r) : req_addr;

  always_ff @(posedge clk) begin
    rd_a_r <= mem_a[rd_addr];
    rd_b_r <= mem_b[rd_addr];
  end

  assign src_data = front_sel_r ? rd_b_r : rd_a_r;

  always_ff @(posedge clk) begin
    if (we_a) mem_a[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[wr_addr] <= wr_data;
  end

  // Pipeline: read data, successor lookup, window line.
  logic                 p1_act_r, p2_act_r, l_act_r;
  logic [DIM_W-1:0]     p1_row_r, p2_row_r, new_row_r;
  logic [COL_W-1:0]     p1_col_r, p2_col_r, new_col_r;
  logic [CELL_BITS-1:0] p2_val_r;
  logic [CELL_BITS-1:0] line_val_r [LINE_LEN];
  logic [SUCC_W-1:0]    line_suc_r [LINE_LEN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_act_r <= 1'b0;
      p2_act_r <= 1'b0;
      l_act_r  <= 1'b0;
    end else begin
      p1_act_r <= iss_act_r;
      p2_act_r <= p1_act_r;
      l_act_r  <= p2_act_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_row_r  <= iss_row_r;
    p1_col_r  <= iss_col_r;
    p2_row_r  <= p1_row_r;
    p2_col_r  <= p1_col_r;
    p2_val_r  <= src_data;
    tbl_rd_r  <= tbl_mem[src_data];
    new_row_r <= p2_row_r;
    new_col_r <= p2_col_r;
  end

  always_ff @(posedge clk) begin
    if (p2_act_r) begin
      line_val_r[0] <= p2_val_r;
      line_suc_r[0] <= tbl_rd_r;
      for (int i = 1; i < LINE_LEN; i++) begin
        line_val_r[i] <= line_val_r[i-1];
        line_suc_r[i] <= line_suc_r[i-1];
      end
    end
  end

  // The cell at the middle tap sits one row above the newest beat.
  logic [DIM_W-1:0] ctr_row;
  logic             has_up, has_down, has_left, has_right;

  assign ctr_row   = new_row_r - 1'b1;
  assign gen_we    = l_act_r && (new_row_r != '0) && (DIM_W'(new_col_r) < cols_used);
  assign has_up    = ctr_row != '0;
  assign has_down  = new_row_r < rows_used;
  assign has_left  = new_col_r != '0;
  assign has_right = (DIM_W'(new_col_r) + DIM_W'(1)) < cols_used;
  assign gen_addr  = cell_addr(ctr_row[ROW_W-1:0], new_col_r);

  // Later neighbors in up, down, left, right order win when several match.
  always_comb begin
    logic [SUCC_W-1:0] mid_ext;
    mid_ext = SUCC_W'(line_val_r[TAP_MID]);
    new_val = line_val_r[TAP_MID];
    if (has_up && line_suc_r[TAP_UP] == mid_ext) new_val = line_val_r[TAP_UP];
    if (has_down && line_suc_r[TAP_DOWN] == mid_ext) new_val = line_val_r[TAP_DOWN];
    if (has_left && line_suc_r[TAP_LEFT] == mid_ext) new_val = line_val_r[TAP_LEFT];
    if (has_right && line_suc_r[TAP_RIGHT] == mid_ext) new_val = line_val_r[TAP_RIGHT];
  end

  assign wr_addr = cmd.cell_write ? req_addr : gen_addr;
  assign wr_data = cmd.cell_write ? wval_r : new_val;
  assign we_a    = (cmd.cell_write && !front_sel_r) || (gen_we && front_sel_r);
  assign we_b    = (cmd.cell_write && front_sel_r) || (gen_we && !front_sel_r);

  // Pending result and output register.
  logic [CELL_BITS-1:0] res_val_r, out_value_r;
  logic                 res_err_r, out_error_r, out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_val_r <= (req_r == REQ_READ && !bad) ? src_data : '0;
      res_err_r <= bad;
    end
    if (cmd.out_load) begin
      out_value_r <= res_val_r;
      out_error_r <= res_err_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

  assign stat.req        = req_r;
  assign stat.bad        = bad;
  assign stat.tbl_last   = tbl_idx_r == '1;
  assign stat.gens_zero  = gens_left_r == '0;
  assign stat.gens_last  = gens_left_r == GEN_W'(1);
  assign stat.sweep_done = !iss_act_r && !p1_act_r && !p2_act_r && !l_act_r;
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

// ===== sv/cyclic_cellular_automaton.sv =====
// Cyclic cellular automaton block: one request at a time on a 64 by 64 grid of
// 8-bit cells held in two buffers. A write or rejected request goes from decode
// straight to the reply state, a read in range passes a read state first. A run
// first builds a 256-entry successor table, then sweeps once per generation: the
// single read port of the source buffer streams every column of each row plus
// one flushing row through a two-row window. No new request is taken until the
// result is in the output register.
// Depends on cca_pkg, cca_ctrl and cca_datapath.
`timescale 1ns / 1ps

module cyclic_cellular_automaton import cca_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // cell_row, cell_col, write_value, zero pad
  input  logic [1:0]             in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // read_value
  output logic                   out_tuser,  // request_error
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic [NS_W-1:0]  num_states_r;
  logic [DIM_W-1:0] grid_rows_r, grid_cols_r;
  logic [GEN_W-1:0] gen_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r <= NS_W'(2);
      grid_rows_r  <= DIM_W'(MAX_ROWS);
      grid_cols_r  <= DIM_W'(MAX_COLS);
      gen_count_r  <= GEN_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NUM_STATES: num_states_r <= cfg_data[NS_W-1:0];
        CFG_GRID_ROWS:  grid_rows_r  <= cfg_data[DIM_W-1:0];
        CFG_GRID_COLS:  grid_cols_r  <= cfg_data[DIM_W-1:0];
        CFG_GEN_COUNT:  gen_count_r  <= cfg_data[GEN_W-1:0];
        default: ;
      endcase
    end
  end

  cca_cmd_t  cmd;
  cca_stat_t stat;

  cca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cca_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_req           (in_tuser),
    .in_row           (in_tdata[ROW_W-1:0]),
    .in_col           (in_tdata[ROW_W+COL_W-1:ROW_W]),
    .in_wval          (in_tdata[ROW_W+COL_W+CELL_BITS-1:ROW_W+COL_W]),
    .num_states       (num_states_r),
    .grid_rows        (grid_rows_r),
    .grid_cols        (grid_cols_r),
    .generation_count (gen_count_r),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .out_value        (out_tdata),
    .out_error        (out_tuser)
  );

  // A taken beat keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken on two consecutive cycles");

  // Buffers swap only once the sweep pipeline has drained.
  a_swap_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gen_end |-> stat.sweep_done)
    else $error("buffer swap with sweep in flight");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.tbl_step, cmd.sweep_start, cmd.gen_end, cmd.out_load}))
    else $error("conflicting sequencer commands");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench of the cyclic cellular automaton: sends write, run and read requests
// on the input stream, predicts each reply with its own grid model and checks the
// result stream beat by beat. Depends on cca_pkg and cyclic_cellular_automaton.

module tb;
  import cca_pkg::*;

  localparam logic [1:0] REQ_UNDEFINED = 2'b11;
  localparam int         LONG_HOLD     = 300;

  typedef struct {
    logic [1:0]           kind;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic [CELL_BITS-1:0] value;
  } cell_req_t;

  typedef struct {
    logic [CELL_BITS-1:0] value;
    logic                 err;
  } cell_reply_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // cell_row, cell_col, write_value, zero pad
  logic [1:0]             in_tuser   = '0;  // req_type
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // read_value
  logic                   out_tuser;        // request_error
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_data   = '0;

  cyclic_cellular_automaton i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Grid model: two banks of cells, a flag per cell that it holds a defined
  // value, and the configuration as the block should see it.
  logic [CELL_BITS-1:0] grid_cells  [2][CELL_COUNT];
  bit                   cell_loaded [2][CELL_COUNT];
  bit                   front_bank = 1'b0;
  logic [NS_W-1:0]      num_states_set = 9'd2;
  logic [DIM_W-1:0]     rows_set       = 7'd64;
  logic [DIM_W-1:0]     cols_set       = 7'd64;
  logic [GEN_W-1:0]     gens_set       = 16'd1;

  cell_req_t   requests_pending [$];
  cell_reply_t replies_due      [$];
  cell_req_t   offered;
  int          send_gap    = 0;
  int          hold_left   = 0;
  int          holds_asked = 0;
  int          holds_done  = 0;
  bit          steady      = 1'b0;
  int          error_count = 0;

  task automatic report(string msg);
    $display("%0t mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic int rows_in_use();
    return (rows_set > MAX_ROWS) ? MAX_ROWS : int'(rows_set);
  endfunction

  function automatic int cols_in_use();
    return (cols_set > MAX_COLS) ? MAX_COLS : int'(cols_set);
  endfunction

  // A modulus of zero means the successor does not wrap.
  function automatic int successor_of(logic [CELL_BITS-1:0] u);
    int s;
    s = int'(u) + 1;
    if (num_states_set != 0) s = s % int'(num_states_set);
    return s;
  endfunction

  function automatic void advance_generation();
    int                   rows;
    int                   cols;
    int                   at;
    bit                   src;
    bit                   dst;
    logic [CELL_BITS-1:0] own;
    logic [CELL_BITS-1:0] next_val;
    rows = rows_in_use();
    cols = cols_in_use();
    src  = front_bank;
    dst  = !front_bank;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        at       = r * MAX_COLS + c;
        own      = grid_cells[src][at];
        next_val = own;
        // Up, down, left, right; a later match overrides an earlier one.
        if (r > 0 && successor_of(grid_cells[src][at - MAX_COLS]) == int'(own))
          next_val = grid_cells[src][at - MAX_COLS];
        if (r + 1 < rows && successor_of(grid_cells[src][at + MAX_COLS]) == int'(own))
          next_val = grid_cells[src][at + MAX_COLS];
        if (c > 0 && successor_of(grid_cells[src][at - 1]) == int'(own))
          next_val = grid_cells[src][at - 1];
        if (c + 1 < cols && successor_of(grid_cells[src][at + 1]) == int'(own))
          next_val = grid_cells[src][at + 1];
        grid_cells[dst][at]  = next_val;
        cell_loaded[dst][at] = 1'b1;
      end
    end
    front_bank = dst;
  endfunction

  function automatic cell_reply_t apply_request(cell_req_t rq);
    cell_reply_t rp;
    bit          in_range;
    int          at;
    rp.value = '0;
    rp.err   = 1'b0;
    in_range = (int'(rq.row) < rows_in_use()) && (int'(rq.col) < cols_in_use());
    at       = int'(rq.row) * MAX_COLS + int'(rq.col);
    case (rq.kind)
      REQ_WRITE: begin
        if (!in_range || rq.value >= num_states_set) begin
          rp.err = 1'b1;
        end else begin
          grid_cells[front_bank][at]  = rq.value;
          cell_loaded[front_bank][at] = 1'b1;
        end
      end
      REQ_RUN: begin
        for (int g = 0; g < int'(gens_set); g++) advance_generation();
      end
      REQ_READ: begin
        if (!in_range) rp.err = 1'b1;
        else rp.value = grid_cells[front_bank][at];
      end
      default: rp.err = 1'b1;
    endcase
    return rp;
  endfunction

  function automatic void apply_config(cfg_reg_t idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_NUM_STATES: num_states_set = val[NS_W-1:0];
      CFG_GRID_ROWS:  rows_set       = val[DIM_W-1:0];
      CFG_GRID_COLS:  cols_set       = val[DIM_W-1:0];
      CFG_GEN_COUNT:  gens_set       = val[GEN_W-1:0];
      default: ;
    endcase
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: the model is advanced at the edge where the block takes the beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) replies_due.push_back(apply_request(offered));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (requests_pending.size() > 0) begin
          offered = requests_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'({offered.value, offered.col, offered.row});
          in_tuser  <= offered.kind;
          send_gap  <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_reply();
    cell_reply_t want;
    if (replies_due.size() == 0) begin
      report($sformatf("reply beat with none pending: value %0d error %0b",
                       out_tdata, out_tuser));
    end else begin
      want = replies_due.pop_front();
      if (out_tdata !== want.value)
        report($sformatf("read_value %0d, predicted %0d", out_tdata, want.value));
      if (out_tuser !== want.err)
        report($sformatf("request_error %0b, predicted %0b", out_tuser, want.err));
    end
  endtask

  // Monitor: random stalls, plus one long hold-off when the stimulus asks.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_reply();
      if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0) begin
        hold_left = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_req(logic [1:0] kind, int row, int col, int value);
    cell_req_t rq;
    rq.kind  = kind;
    rq.row   = row[ROW_W-1:0];
    rq.col   = col[COL_W-1:0];
    rq.value = value[CELL_BITS-1:0];
    requests_pending.push_back(rq);
  endtask

  // Sampled on the falling edge so that every update of the rising edge is seen.
  task automatic wait_idle();
    do @(negedge clk);
    while (requests_pending.size() != 0 || in_tvalid || replies_due.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    apply_config(idx, value[CFG_W-1:0]);
  endtask

  task automatic set_config(int states, int rows, int cols, int gens);
    write_reg(CFG_NUM_STATES, states);
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
    write_reg(CFG_GEN_COUNT, gens);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One phase: reconfigure while idle, define every cell in use, then a mix of
  // requests. Reads in range are safe because each cell in use is defined and a
  // run only ever produces defined cells from defined ones.
  task automatic random_phase(int states, int rows, int cols, int gens, int mix_items,
                              int run_pct, bit no_idle, bit long_hold);
    int roll;
    int at;
    wait_idle();
    set_config(states, rows, cols, gens);
    steady = no_idle;
    if (long_hold) holds_asked++;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        at = r * MAX_COLS + c;
        if (!cell_loaded[front_bank][at])
          push_req(REQ_WRITE, r, c, $urandom_range(0, states - 1));
      end
    end
    for (int n = 0; n < mix_items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < run_pct)
        push_req(REQ_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 255));
      else if (roll < run_pct + 40)
        push_req(REQ_WRITE, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                 $urandom_range(0, states - 1));
      else if (roll < run_pct + 70)
        push_req(REQ_READ, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                 $urandom_range(0, 255));
      else if (roll < run_pct + 80)
        push_req(REQ_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 255));
      else if (roll < run_pct + 92)
        push_req(REQ_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 255));
      else
        push_req(REQ_UNDEFINED, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 255));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: two states on the full grid; corner cells, values equal
    // to and far above the modulus, and the unknown request kind.
    push_req(REQ_WRITE, 0, 0, 1);
    push_req(REQ_WRITE, 63, 63, 0);
    push_req(REQ_WRITE, 10, 20, 2);
    push_req(REQ_WRITE, 1, 1, 255);
    push_req(REQ_READ, 0, 0, 0);
    push_req(REQ_READ, 63, 63, 255);
    push_req(REQ_UNDEFINED, 63, 63, 255);
    push_req(REQ_UNDEFINED, 0, 0, 0);
    wait_idle();

    // Widest modulus, so every 8-bit value is legal.
    set_config(256, 64, 64, 1);
    push_req(REQ_WRITE, 63, 0, 255);
    push_req(REQ_WRITE, 0, 63, 128);
    push_req(REQ_READ, 63, 0, 0);
    push_req(REQ_READ, 0, 63, 0);
    push_req(REQ_WRITE, 63, 63, 255);
    push_req(REQ_READ, 63, 63, 0);
    wait_idle();

    // Single-cell grid: positions out of range and a run of zero generations.
    set_config(2, 1, 1, 0);
    push_req(REQ_READ, 0, 1, 0);
    push_req(REQ_READ, 1, 0, 0);
    push_req(REQ_WRITE, 63, 63, 1);
    push_req(REQ_RUN, 0, 0, 0);
    push_req(REQ_READ, 0, 0, 0);
    wait_idle();

    set_config(2, 1, 1, 1);
    push_req(REQ_RUN, 0, 0, 0);
    push_req(REQ_READ, 0, 0, 0);

    random_phase(3, 3, 4, 1, 14, 8, 1'b0, 1'b0);
    random_phase(4, 4, 4, 3, 12, 8, 1'b1, 1'b0);
    random_phase(1, 2, 3, 2, 12, 10, 1'b0, 1'b1);
    random_phase(256, 1, 16, 2, 10, 10, 1'b0, 1'b0);
    random_phase(5, 2, 3, 200, 16, 8, 1'b0, 1'b0);
    random_phase(3, 5, 2, 65535, 10, 0, 1'b1, 1'b0);
    random_phase(2, 4, 3, 7, 16, 10, 1'b0, 1'b0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (replies_due.size() != 0)
      report($sformatf("%0d replies never arrived", replies_due.size()));
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
